// ----- rtl/core/tkrt_pkg.sv -----
package tkrt_pkg;

    // field widths fixed by the item format
    localparam int ID_W       = 32;
    localparam int IN_SCORE_W = 32;
    localparam int SCORE_W    = 48;
    localparam int MODE_W     = 2;
    localparam int CAP_W      = 7;
    localparam int OUT_W      = 7;

    // widest position or count a cell ever compares against (table depth up to 2047)
    localparam int MAX_CNT_W  = 11;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'd1;

    // function codes carried in tuser
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // rank reported for an absent id
    localparam logic [OUT_W-1:0] RANK_NONE = {OUT_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_OVERWRITE   = 2'd0,
        MODE_KEEP_LARGER = 2'd1,
        MODE_ADD         = 2'd2,
        MODE_HOLD        = 2'd3
    } update_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LOCATE,
        ST_SCORE,
        ST_PLACE,
        ST_FIND,
        ST_MOVE
    } tkrt_state_t;

    typedef logic signed [SCORE_W-1:0] score_t;

    // broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic                 flag_en;
        logic                 cmp_en;
        logic                 move_en;
        logic                 up;
        logic [MAX_CNT_W-1:0] count;
        logic [MAX_CNT_W-1:0] key_pos;
        logic [MAX_CNT_W-1:0] tgt_pos;
        logic [ID_W-1:0]      id;
        logic [SCORE_W-1:0]   score;
    } tkrt_cell_ctrl_t;

    // per-cell flags back to the sequencer
    typedef struct packed {
        logic match;
        logic ge;
        logic cmp;
    } tkrt_cell_stat_t;

endpackage

// ----- rtl/core/tkrt_cell.sv -----
module tkrt_cell
    import tkrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MAX_CNT_W-1:0] pos,
    input  tkrt_cell_ctrl_t      ctrl,
    input  logic [ID_W-1:0]      left_id,
    input  score_t               left_score,
    input  logic [ID_W-1:0]      right_id,
    input  score_t               right_score,
    output logic [ID_W-1:0]      id,
    output score_t               score,
    output tkrt_cell_stat_t      stat
);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    score_t          score_reg;
    score_t          score_next;
    logic            match_reg;
    logic            match_next;
    logic            ge_reg;
    logic            ge_next;
    logic            cmp_reg;
    logic            cmp_next;
    logic            valid;
    logic            is_key;
    logic            below_key;
    score_t          ref_score;

    assign valid     = pos < ctrl.count;
    assign is_key    = pos == ctrl.key_pos;
    assign below_key = pos < ctrl.key_pos;
    assign ref_score = $signed(ctrl.score);

    always_comb
    begin
        id_next    = id_reg;
        score_next = score_reg;
        match_next = match_reg;
        ge_next    = ge_reg;
        cmp_next   = cmp_reg;
        if (ctrl.flag_en)
        begin
            match_next = valid && (id_reg == ctrl.id);
            ge_next    = valid && (score_reg >= ref_score);
        end
        if (ctrl.cmp_en)
        begin
            // up: entries above the key that stay ahead; down: key and everything ahead
            if (ctrl.up)
                cmp_next = valid && below_key && (score_reg >= ref_score);
            else
                cmp_next = is_key || (valid && (score_reg > ref_score));
        end
        if (ctrl.move_en)
        begin
            if (pos == ctrl.tgt_pos)
            begin
                id_next    = ctrl.id;
                score_next = ref_score;
            end
            else if (ctrl.up && (pos > ctrl.tgt_pos) && (pos <= ctrl.key_pos))
            begin
                id_next    = left_id;
                score_next = left_score;
            end
            else if (!ctrl.up && (pos >= ctrl.key_pos) && (pos < ctrl.tgt_pos))
            begin
                id_next    = right_id;
                score_next = right_score;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            ge_reg    <= 1'b0;
            cmp_reg   <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            ge_reg    <= ge_next;
            cmp_reg   <= cmp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

    assign id         = id_reg;
    assign score      = score_reg;
    assign stat.match = match_reg;
    assign stat.ge    = ge_reg;
    assign stat.cmp   = cmp_reg;

endmodule

// ----- rtl/core/top_k_ranked_table_core.sv -----
// the result beat enters the output register at the end of the move pass
// a new item is taken only in idle, once the sequencer has made its passes over the cell row
//   (match, locate, score, place, find target, move)
// a result beat still held in the output register stretches the move pass until m_tready
// reset: sequencer, valid count, control and configuration registers and output valid cleared at once;
//   the cell contents are not cleared, cells past the valid count are never looked at
module top_k_ranked_table_core
    import tkrt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // item_id[31:0], item_score[63:32]
    input  logic [0:0]           s_tuser,   // func[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // accepted[0], rank_index[7:1], entry_count[14:8]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAP_W-1:0]     cfg_wdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // sequencer and configuration
    tkrt_state_t          state_reg;
    tkrt_state_t          state_next;
    update_mode_t         mode_reg;
    logic [CAP_W-1:0]     cap_reg;

    // captured item
    logic                 func_reg;
    logic [ID_W-1:0]      id_reg;
    score_t               s_reg;

    // table occupancy
    logic [CW-1:0]        count_reg;

    // lookup results
    logic                 found_reg;
    logic [IW-1:0]        key_reg;
    score_t               old_reg;
    logic [CW-1:0]        ins_pos_reg;

    // decision for the move pass
    score_t               v_reg;
    score_t               v_next;
    logic                 up_reg;
    logic                 up_next;
    logic                 move_reg;
    logic                 move_next;
    logic [CW-1:0]        kpos_reg;
    logic [CW-1:0]        kpos_next;
    logic                 acc_reg;
    logic                 acc_next;
    logic [OUT_W-1:0]     rank_reg;
    logic [OUT_W-1:0]     rank_next;
    logic [CW-1:0]        cnt_new_reg;
    logic [CW-1:0]        cnt_new_next;
    logic [IW-1:0]        tgt_reg;
    logic [IW-1:0]        tgt_next;

    // output register
    logic                 m_valid_reg;
    logic [15:0]          m_data_reg;
    logic                 out_free;
    logic [OUT_W-1:0]     rank_out;

    // cell row
    tkrt_cell_ctrl_t      ctrl;
    logic [ID_W-1:0]      id_w    [DEPTH];
    score_t               score_w [DEPTH];
    tkrt_cell_stat_t      stat_w  [DEPTH];

    // row reductions
    logic [DEPTH-1:0]     match_vec;
    logic [DEPTH-1:0]     cmp_edge;
    logic [IW-1:0]        key_idx;
    score_t               old_sc;
    logic                 ge_any;
    logic [IW-1:0]        ge_pos;
    logic                 ge_prev;
    logic                 cmp_any;
    logic [IW-1:0]        cmp_pos;
    logic                 cmp_prev;
    logic [CW-1:0]        ins_pos;
    logic [CW-1:0]        first_free;
    logic [CW-1:0]        tgt_full;

    // score stage
    logic [LW-1:0]        cap_ext;
    logic [LW-1:0]        depth_ext;
    logic [LW-1:0]        cap_eff;
    logic                 full;
    logic signed [SCORE_W:0] sum;
    score_t               sat_sum;
    logic [OUT_W-1:0]     key_rank;

    assign out_free = !m_valid_reg || m_tready;

    // ---------------- cell row ----------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [ID_W-1:0] l_id;
        score_t          l_score;
        logic [ID_W-1:0] r_id;
        score_t          r_score;

        // end cells never take from outside the row, tie to their own contents
        if (g == 0)
        begin : g_first
            assign l_id    = id_w[g];
            assign l_score = score_w[g];
        end
        else
        begin : g_left
            assign l_id    = id_w[g-1];
            assign l_score = score_w[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign r_id    = id_w[g];
            assign r_score = score_w[g];
        end
        else
        begin : g_right
            assign r_id    = id_w[g+1];
            assign r_score = score_w[g+1];
        end

        tkrt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .pos         (MAX_CNT_W'(g)),
            .ctrl        (ctrl),
            .left_id     (l_id),
            .left_score  (l_score),
            .right_id    (r_id),
            .right_score (r_score),
            .id          (id_w[g]),
            .score       (score_w[g]),
            .stat        (stat_w[g])
        );
    end

    // ---------------- row reductions ----------------
    // ids are unique, so at most one cell matches and an OR picks index and score;
    // ge and cmp flags are prefixes, so their only falling edge marks the position
    always_comb
    begin
        match_vec = '0;
        cmp_edge  = '0;
        key_idx   = '0;
        old_sc    = '0;
        ge_any    = 1'b0;
        ge_pos    = '0;
        ge_prev   = 1'b1;
        cmp_any   = 1'b0;
        cmp_pos   = '0;
        cmp_prev  = 1'b1;
        for (int j = 0; j < DEPTH; j++)
        begin
            match_vec[j] = stat_w[j].match;
            if (stat_w[j].match)
            begin
                key_idx = key_idx | IW'(j);
                old_sc  = old_sc | score_w[j];
            end
            if (ge_prev && !stat_w[j].ge)
            begin
                ge_any = 1'b1;
                ge_pos = ge_pos | IW'(j);
            end
            ge_prev     = stat_w[j].ge;
            cmp_edge[j] = cmp_prev && !stat_w[j].cmp;
            if (cmp_edge[j])
            begin
                cmp_any = 1'b1;
                cmp_pos = cmp_pos | IW'(j);
            end
            cmp_prev = stat_w[j].cmp;
        end
    end

    // insert point: after every entry with a score at least the new one
    assign ins_pos    = ge_any  ? CW'(ge_pos)  : CW'(DEPTH);
    assign first_free = cmp_any ? CW'(cmp_pos) : CW'(DEPTH);
    // moving down the key itself sits in the prefix, so the target is one short
    assign tgt_full   = up_reg ? first_free : first_free - CW'(1);
    assign tgt_next   = tgt_full[IW-1:0];

    // ---------------- score stage ----------------
    assign cap_ext   = LW'(cap_reg);
    assign depth_ext = LW'(DEPTH);
    assign cap_eff   = ((cap_reg == '0) || (cap_ext > depth_ext)) ? depth_ext : cap_ext;
    assign full      = LW'(count_reg) >= cap_eff;
    assign key_rank  = found_reg ? OUT_W'(key_reg) : RANK_NONE;

    // saturating add on a 49-bit sum
    assign sum = $signed({old_reg[SCORE_W-1], old_reg}) + $signed({s_reg[SCORE_W-1], s_reg});
    always_comb
    begin
        case (sum[SCORE_W:SCORE_W-1])
            2'b01:   sat_sum = {1'b0, {(SCORE_W-1){1'b1}}};
            2'b10:   sat_sum = {1'b1, {(SCORE_W-1){1'b0}}};
            default: sat_sum = sum[SCORE_W-1:0];
        endcase
    end

    always_comb
    begin
        v_next       = s_reg;
        up_next      = 1'b1;
        move_next    = 1'b0;
        kpos_next    = CW'(key_reg);
        acc_next     = 1'b0;
        rank_next    = key_rank;
        cnt_new_next = count_reg;
        if (func_reg == FUNC_PUSH)
        begin
            if (!found_reg)
            begin
                // a full table refuses unless the new score beats the last entry
                if (!(full && (ins_pos_reg == count_reg)))
                begin
                    acc_next  = 1'b1;
                    move_next = 1'b1;
                    if (full)
                    begin
                        kpos_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        kpos_next    = count_reg;
                        cnt_new_next = count_reg + CW'(1);
                    end
                end
            end
            else
            begin
                acc_next  = 1'b1;
                move_next = 1'b1;
                case (mode_reg)
                    MODE_OVERWRITE:   v_next = s_reg;
                    MODE_KEEP_LARGER:
                    begin
                        if (old_reg >= s_reg)
                        begin
                            acc_next  = 1'b0;
                            move_next = 1'b0;
                        end
                    end
                    MODE_ADD:         v_next = sat_sum;
                    MODE_HOLD:        v_next = old_reg;
                    default:          v_next = old_reg;
                endcase
                up_next = v_next >= old_reg;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_MATCH;
            ST_MATCH:  state_next = ST_LOCATE;
            ST_LOCATE: state_next = ST_SCORE;
            ST_SCORE:  state_next = ST_PLACE;
            ST_PLACE:  state_next = ST_FIND;
            ST_FIND:   state_next = ST_MOVE;
            ST_MOVE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        ctrl.flag_en = 1'b0;
        ctrl.cmp_en  = 1'b0;
        ctrl.move_en = 1'b0;
        ctrl.score   = v_reg;
        ctrl.up      = up_reg;
        ctrl.count   = MAX_CNT_W'(count_reg);
        ctrl.key_pos = MAX_CNT_W'(kpos_reg);
        ctrl.tgt_pos = MAX_CNT_W'(tgt_reg);
        ctrl.id      = id_reg;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_MATCH:
            begin
                ctrl.flag_en = 1'b1;
                ctrl.score   = s_reg;
            end
            ST_PLACE: ctrl.cmp_en = 1'b1;
            ST_MOVE:  ctrl.move_en = out_free && move_reg;
            default:  s_tready = 1'b0;
        endcase
    end

    assign rank_out = move_reg ? OUT_W'(tgt_reg) : rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_OVERWRITE;
            cap_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            move_reg    <= 1'b0;
            up_reg      <= 1'b1;
            found_reg   <= 1'b0;
            acc_reg     <= 1'b0;
            func_reg    <= FUNC_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UPDATE_MODE:    mode_reg <= update_mode_t'(cfg_wdata[MODE_W-1:0]);
                    REG_CAPACITY_LIMIT: cap_reg  <= cfg_wdata;
                    default:            cap_reg  <= cap_reg;
                endcase
            end
            if (s_tvalid && s_tready)
                func_reg <= s_tuser[0];
            if (state_reg == ST_LOCATE)
                found_reg <= |match_vec;
            if (state_reg == ST_SCORE)
            begin
                move_reg <= move_next;
                up_reg   <= up_next;
                acc_reg  <= acc_next;
            end
            if ((state_reg == ST_MOVE) && out_free)
            begin
                count_reg   <= cnt_new_reg;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            id_reg <= s_tdata[ID_W-1:0];
            s_reg  <= {{(SCORE_W-IN_SCORE_W){s_tdata[63]}}, s_tdata[63:32]};
        end
        if (state_reg == ST_LOCATE)
        begin
            key_reg     <= key_idx;
            old_reg     <= old_sc;
            ins_pos_reg <= ins_pos;
        end
        if (state_reg == ST_SCORE)
        begin
            v_reg       <= v_next;
            kpos_reg    <= kpos_next;
            rank_reg    <= rank_next;
            cnt_new_reg <= cnt_new_next;
        end
        if (state_reg == ST_FIND)
            tgt_reg <= tgt_next;
        if ((state_reg == ST_MOVE) && out_free)
            m_data_reg <= {1'b0, OUT_W'(cnt_new_reg), rank_out, acc_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("valid count beyond table depth");

    a_unique_id: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOCATE) |-> $onehot0(match_vec))
        else $error("id stored in more than one cell");

    a_single_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> $onehot0(cmp_edge))
        else $error("compare flags do not form a prefix");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg == ST_MOVE)
                                 && (count_reg == $past(count_reg) + CW'(1))))
        else $error("count changed outside an insert");

    a_query_still: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCORE && func_reg == FUNC_QUERY) |=> !move_reg)
        else $error("query would modify the table");

endmodule
